/* hw/rtl/coe_pkg.sv */
// Package for the opcode-subset cycle executor: widths, register indexes and flag bits.
// No dependencies.
package coe_pkg;
  localparam int unsigned AddrW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned NumRegs = 8;

  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegC = 3'd1;
  localparam logic [2:0] RegD = 3'd2;
  localparam logic [2:0] RegE = 3'd3;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;
  localparam logic [2:0] RegF = 3'd6;
  localparam logic [2:0] RegA = 3'd7;

  localparam int unsigned FlagZ = 7;
  localparam int unsigned FlagN = 6;
  localparam int unsigned FlagH = 5;
  localparam int unsigned FlagC = 4;

  localparam logic [15:0] HighPage = 16'hFF00;

  typedef struct packed {
    logic [7:0] op;
    logic       prefixed;
    logic [2:0] phase;
    logic [7:0] read_byte;
  } coe_in_t;

  typedef struct packed {
    logic [2:0]  next_phase;
    logic        failed;
    logic [15:0] bus_address;
    logic        address_valid;
    logic [7:0]  store_byte;
    logic        store_valid;
    logic        stop_requested;
    logic [15:0] program_counter;
  } coe_out_t;
endpackage

/* hw/rtl/coe_if.sv */
// Valid/ready channel interface carrying one payload of a chosen type.
// The payload type is a parameter; the interface itself has no dependencies.
interface coe_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/cpu_opcode_subset_cycle_executor.sv */
// Top level of the opcode-subset cycle executor: architectural state and result register.
// Depends on coe_pkg and coe_if.
//
//  channel  | dir | payload
//  in_ch    | in  | op, prefixed, phase, read_byte
//  out_ch   | out | next_phase, failed, bus_address, address_valid, store_byte,
//           |     | store_valid, stop_requested, program_counter
//
// One machine cycle is taken per clock unless out_ch stalls: a transfer on in_ch updates
// the state and loads the result register at that same edge, through the single decode
// stage, so the result is offered on out_ch in the cycle after the transfer.
// The input is accepted whenever the result register is empty or being drained.
// Reset clears all CPU registers, PC, SP, the temporaries and the stop flag.
module cpu_opcode_subset_cycle_executor
  import coe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  coe_if.sink   in_ch,
  coe_if.source out_ch
);
  logic [7:0]  regs_q [NumRegs];
  logic [7:0]  regs_d [NumRegs];
  logic [15:0] pc_q, pc_d, sp_q, sp_d;
  logic [7:0]  tlo_q, tlo_d, thi_q, thi_d;
  logic        stop_q, stop_d;
  logic        ovalid_q;
  coe_out_t    res_q, res_d;
  logic        fire;

  assign in_ch.ready  = !ovalid_q || out_ch.ready;
  assign fire         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = res_q;

  // Decode and execute one machine cycle.
  always_comb begin
    logic [7:0]  op, rd;
    logic [2:0]  ph, np;
    logic [1:0]  p;
    logic        bad, av, sv, take;
    logic [15:0] addr, pc1, pairv, pairaf, hl, ret;
    logic [7:0]  sb, v, a, n;
    logic [2:0]  r;
    op = in_ch.data.op; rd = in_ch.data.read_byte; ph = in_ch.data.phase;
    p = op[5:4];
    np = '0; bad = 1'b0; av = 1'b0; sv = 1'b0; addr = '0; sb = '0;
    take = 1'b0; v = '0; a = regs_q[RegA]; n = '0; r = RegA;
    for (int i = 0; i < NumRegs; i++) regs_d[i] = regs_q[i];
    pc_d = pc_q; sp_d = sp_q; tlo_d = tlo_q; thi_d = thi_q; stop_d = stop_q;
    pc1 = pc_q + 16'd1;
    hl = {regs_q[RegH], regs_q[RegL]};
    ret = '0;
    case (p)
      2'd0: pairv = {regs_q[RegB], regs_q[RegC]};
      2'd1: pairv = {regs_q[RegD], regs_q[RegE]};
      2'd2: pairv = hl;
      default: pairv = sp_q;
    endcase
    pairaf = (p == 2'd3) ? {regs_q[RegA], regs_q[RegF]} : pairv;
    if (in_ch.data.prefixed) begin
      bad = 1'b1;
    end else begin
      case (op)
        8'h00, 8'hF3: begin
          if (ph == 3'd0) pc_d = pc1; else bad = 1'b1;
        end
        8'h10: begin
          if (ph == 3'd0) begin pc_d = pc1; np = 3'd1; end
          else if (ph == 3'd1) begin pc_d = pc1; stop_d = 1'b1; end
          else bad = 1'b1;
        end
        8'h18, 8'h20, 8'h28, 8'h30: begin
          case (op)
            8'h18: take = 1'b1;
            8'h20: take = !regs_q[RegF][FlagZ];
            8'h28: take = regs_q[RegF][FlagZ];
            default: take = !regs_q[RegF][FlagC];
          endcase
          if (ph == 3'd0) begin
            pc_d = pc1; addr = pc1; av = 1'b1; np = take ? 3'd2 : 3'd1;
          end else if (ph == 3'd2) begin
            pc_d = pc1; np = 3'd1;
          end else if (ph == 3'd1) begin
            pc_d = take ? pc_q + {{8{rd[7]}}, rd} : pc1;
          end else bad = 1'b1;
        end
        8'h01, 8'h11, 8'h21, 8'h31: begin
          if (ph == 3'd0) begin
            pc_d = pc1; addr = pc1; av = 1'b1; np = 3'd2;
          end else if (ph == 3'd2 || ph == 3'd1) begin
            pc_d = pc1;
            if (ph == 3'd2) begin addr = pc1; av = 1'b1; np = 3'd1; end
            case (p)
              2'd0: if (ph == 3'd2) regs_d[RegC] = rd; else regs_d[RegB] = rd;
              2'd1: if (ph == 3'd2) regs_d[RegE] = rd; else regs_d[RegD] = rd;
              2'd2: if (ph == 3'd2) regs_d[RegL] = rd; else regs_d[RegH] = rd;
              default: if (ph == 3'd2) sp_d = {sp_q[15:8], rd};
                       else sp_d = {rd, sp_q[7:0]};
            endcase
          end else bad = 1'b1;
        end
        8'h02: begin
          if (ph == 3'd0) begin pc_d = pc1; np = 3'd1; end
          else if (ph == 3'd1) begin
            addr = {regs_q[RegB], regs_q[RegC]}; av = 1'b1; sb = a; sv = 1'b1;
          end else bad = 1'b1;
        end
        8'h03, 8'h13, 8'h23, 8'h33, 8'h0B: begin
          if (ph == 3'd0) begin
            pc_d = pc1; np = 3'd1;
            ret = pairv + ((op == 8'h0B) ? 16'hFFFF : 16'd1);
            case (p)
              2'd0: begin regs_d[RegB] = ret[15:8]; regs_d[RegC] = ret[7:0]; end
              2'd1: begin regs_d[RegD] = ret[15:8]; regs_d[RegE] = ret[7:0]; end
              2'd2: begin regs_d[RegH] = ret[15:8]; regs_d[RegL] = ret[7:0]; end
              default: sp_d = ret;
            endcase
          end else if (ph != 3'd1) bad = 1'b1;
        end
        8'h0C, 8'h1C, 8'h2C, 8'h3C: begin
          if (ph == 3'd0) begin
            case (p)
              2'd0: r = RegC;
              2'd1: r = RegE;
              2'd2: r = RegL;
              default: r = RegA;
            endcase
            v = regs_q[r] + 8'd1;
            regs_d[r] = v;
            pc_d = pc1;
            regs_d[RegF] = {v == 8'd0, 1'b0, v[3:0] == 4'd0, regs_q[RegF][FlagC], 4'd0};
          end else bad = 1'b1;
        end
        8'h06, 8'h0E, 8'h3E, 8'hFE: begin
          if (ph == 3'd0) begin
            pc_d = pc1; addr = pc1; av = 1'b1; np = 3'd1;
          end else if (ph == 3'd1) begin
            pc_d = pc1;
            case (op)
              8'h06: regs_d[RegB] = rd;
              8'h0E: regs_d[RegC] = rd;
              8'h3E: regs_d[RegA] = rd;
              default: regs_d[RegF] = {a == rd, 1'b1, rd[3:0] > a[3:0], rd > a, 4'd0};
            endcase
          end else bad = 1'b1;
        end
        8'h47, 8'h4F, 8'h78, 8'h79, 8'h7C, 8'h7D, 8'hAF, 8'hB1, 8'hB8: begin
          if (ph != 3'd0) bad = 1'b1;
          else begin
            pc_d = pc1;
            n = regs_q[RegB];
            case (op)
              8'h47: regs_d[RegB] = a;
              8'h4F: regs_d[RegC] = a;
              8'h78: regs_d[RegA] = regs_q[RegB];
              8'h79: regs_d[RegA] = regs_q[RegC];
              8'h7C: regs_d[RegA] = regs_q[RegH];
              8'h7D: regs_d[RegA] = regs_q[RegL];
              8'hAF: begin regs_d[RegA] = '0; regs_d[RegF] = 8'h80; end
              8'hB1: begin
                v = a | regs_q[RegC];
                regs_d[RegA] = v;
                regs_d[RegF] = {v == 8'd0, 7'd0};
              end
              default: regs_d[RegF] = {a == n, 1'b1, n[3:0] > a[3:0], n > a, 4'd0};
            endcase
          end
        end
        8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
          if (ph == 3'd0) begin
            pc_d = pc1; addr = sp_q; av = 1'b1; np = 3'd2;
          end else if (ph == 3'd2 || ph == 3'd1) begin
            sp_d = sp_q + 16'd1;
            if (ph == 3'd2) begin addr = sp_d; av = 1'b1; np = 3'd1; end
            case (p)
              2'd0: if (ph == 3'd2) regs_d[RegC] = rd; else regs_d[RegB] = rd;
              2'd1: if (ph == 3'd2) regs_d[RegE] = rd; else regs_d[RegD] = rd;
              2'd2: if (ph == 3'd2) regs_d[RegL] = rd; else regs_d[RegH] = rd;
              default: if (ph == 3'd2) regs_d[RegF] = {rd[7:4], 4'd0};
                       else regs_d[RegA] = rd;
            endcase
          end else bad = 1'b1;
        end
        8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
          if (ph == 3'd0) begin pc_d = pc1; np = 3'd3; end
          else if (ph == 3'd3 || ph == 3'd2) begin
            sp_d = sp_q - 16'd1; addr = sp_d; av = 1'b1; sv = 1'b1;
            sb = (ph == 3'd3) ? pairaf[15:8] : pairaf[7:0];
            np = ph - 3'd1;
          end else if (ph != 3'd1) bad = 1'b1;
        end
        8'hC3, 8'hEA, 8'hFA: begin
          if (ph == 3'd0) begin
            pc_d = pc1; addr = pc1; av = 1'b1; np = 3'd3;
          end else if (ph == 3'd3) begin
            pc_d = pc1; tlo_d = rd; addr = pc1; av = 1'b1; np = 3'd2;
          end else if (ph == 3'd2) begin
            pc_d = pc1; np = 3'd1;
            if (op != 8'hC3) begin addr = {rd, tlo_q}; av = 1'b1; end
            if (op == 8'hEA) begin sb = a; sv = 1'b1; end
          end else if (ph == 3'd1) begin
            if (op == 8'hC3) pc_d = {rd, tlo_q};
            else if (op == 8'hFA) regs_d[RegA] = rd;
          end else bad = 1'b1;
        end
        8'hC9: begin
          if (ph == 3'd0) begin
            pc_d = pc1; addr = sp_q; av = 1'b1; sp_d = sp_q + 16'd1; np = 3'd3;
          end else if (ph == 3'd3) begin
            tlo_d = rd; addr = sp_q; av = 1'b1; sp_d = sp_q + 16'd1; np = 3'd2;
          end else if (ph == 3'd2) begin
            pc_d = {rd, tlo_q}; np = 3'd1;
          end else if (ph != 3'd1) bad = 1'b1;
        end
        8'hCD: begin
          if (ph == 3'd0) begin
            pc_d = pc1; addr = pc1; av = 1'b1; np = 3'd5;
          end else if (ph == 3'd5) begin
            pc_d = pc1; tlo_d = rd; addr = pc1; av = 1'b1; np = 3'd4;
          end else if (ph == 3'd4) begin
            pc_d = {rd, tlo_q}; thi_d = pc1[7:0]; tlo_d = pc1[15:8]; np = 3'd3;
          end else if (ph == 3'd3 || ph == 3'd2) begin
            sp_d = sp_q - 16'd1; addr = sp_d; av = 1'b1; sv = 1'b1;
            sb = (ph == 3'd3) ? tlo_q : thi_q;
            np = ph - 3'd1;
          end else if (ph != 3'd1) bad = 1'b1;
        end
        8'h2A: begin
          if (ph == 3'd0) begin
            ret = hl + 16'd1;
            pc_d = pc1; addr = hl; av = 1'b1; np = 3'd1;
            regs_d[RegH] = ret[15:8]; regs_d[RegL] = ret[7:0];
          end else if (ph == 3'd1) regs_d[RegA] = rd;
          else bad = 1'b1;
        end
        8'hE0, 8'hF0: begin
          if (ph == 3'd0) begin
            pc_d = pc1; addr = pc1; av = 1'b1; np = 3'd2;
          end else if (ph == 3'd2) begin
            pc_d = pc1; addr = HighPage | {8'd0, rd}; av = 1'b1; np = 3'd1;
            if (op == 8'hE0) begin sb = a; sv = 1'b1; end
          end else if (ph == 3'd1) begin
            if (op == 8'hF0) regs_d[RegA] = rd;
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
    end
    // A failed cycle leaves every piece of state untouched.
    if (bad) begin
      for (int i = 0; i < NumRegs; i++) regs_d[i] = regs_q[i];
      pc_d = pc_q; sp_d = sp_q; tlo_d = tlo_q; thi_d = thi_q; stop_d = stop_q;
      np = '0; av = 1'b0; sv = 1'b0;
    end
    res_d.next_phase      = np;
    res_d.failed          = bad;
    res_d.bus_address     = av ? addr : 16'd0;
    res_d.address_valid   = av;
    res_d.store_byte      = sv ? sb : 8'd0;
    res_d.store_valid     = sv;
    res_d.stop_requested  = stop_d;
    res_d.program_counter = pc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
      pc_q <= '0; sp_q <= '0; tlo_q <= '0; thi_q <= '0; stop_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (fire) begin
        for (int i = 0; i < NumRegs; i++) regs_q[i] <= regs_d[i];
        pc_q <= pc_d; sp_q <= sp_d; tlo_q <= tlo_d; thi_q <= thi_d; stop_q <= stop_d;
        ovalid_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end
endmodule

/* dv/tb_top.sv */
// Testbench for the opcode-subset cycle executor: directed and random machine cycles.
// Depends on coe_pkg, coe_if and cpu_opcode_subset_cycle_executor.
`timescale 1ns / 100ps

module tb_top;
  import coe_pkg::*;

  logic clk_i;
  logic rst_ni;

  coe_if #(.payload_t(coe_in_t))  in_ch ();
  coe_if #(.payload_t(coe_out_t)) out_ch ();

  cpu_opcode_subset_cycle_executor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Opcodes that the block implements, and one unused opcode that it does not.
  localparam logic [7:0] OpNop    = 8'h00, OpLdBcD16 = 8'h01, OpLdBcA  = 8'h02;
  localparam logic [7:0] OpIncBc  = 8'h03, OpLdBD8   = 8'h06, OpDecBc  = 8'h0B;
  localparam logic [7:0] OpIncC   = 8'h0C, OpLdCD8   = 8'h0E, OpStop   = 8'h10;
  localparam logic [7:0] OpLdDeD16 = 8'h11, OpIncDe  = 8'h13, OpJr     = 8'h18;
  localparam logic [7:0] OpIncE   = 8'h1C, OpJrNz    = 8'h20, OpLdHlD16 = 8'h21;
  localparam logic [7:0] OpIncHl  = 8'h23, OpJrZ     = 8'h28, OpLdAHli = 8'h2A;
  localparam logic [7:0] OpIncL   = 8'h2C, OpJrNc    = 8'h30, OpLdSpD16 = 8'h31;
  localparam logic [7:0] OpIncSp  = 8'h33, OpIncA    = 8'h3C, OpLdAD8  = 8'h3E;
  localparam logic [7:0] OpLdBA   = 8'h47, OpLdCA    = 8'h4F, OpLdAB   = 8'h78;
  localparam logic [7:0] OpLdAC   = 8'h79, OpLdAH    = 8'h7C, OpLdAL   = 8'h7D;
  localparam logic [7:0] OpXorA   = 8'hAF, OpOrC     = 8'hB1, OpCpB    = 8'hB8;
  localparam logic [7:0] OpPopBc  = 8'hC1, OpJp      = 8'hC3, OpPushBc = 8'hC5;
  localparam logic [7:0] OpRet    = 8'hC9, OpCall    = 8'hCD, OpPopDe  = 8'hD1;
  localparam logic [7:0] OpPushDe = 8'hD5, OpLdhA8A  = 8'hE0, OpPopHl  = 8'hE1;
  localparam logic [7:0] OpPushHl = 8'hE5, OpLdA16A  = 8'hEA, OpLdhAA8 = 8'hF0;
  localparam logic [7:0] OpPopAf  = 8'hF1, OpDi      = 8'hF3, OpPushAf = 8'hF5;
  localparam logic [7:0] OpLdAA16 = 8'hFA, OpCpD8    = 8'hFE, OpUnused = 8'hFF;

  localparam logic [7:0] KnownOps [50] = '{
    OpNop, OpLdBcD16, OpLdBcA, OpIncBc, OpLdBD8, OpDecBc, OpIncC, OpLdCD8, OpStop,
    OpLdDeD16, OpIncDe, OpJr, OpIncE, OpJrNz, OpLdHlD16, OpIncHl, OpJrZ, OpLdAHli,
    OpIncL, OpJrNc, OpLdSpD16, OpIncSp, OpIncA, OpLdAD8, OpLdBA, OpLdCA, OpLdAB,
    OpLdAC, OpLdAH, OpLdAL, OpXorA, OpOrC, OpCpB, OpPopBc, OpJp, OpPushBc, OpRet,
    OpCall, OpPopDe, OpPushDe, OpLdhA8A, OpPopHl, OpPushHl, OpLdA16A, OpLdhAA8,
    OpPopAf, OpDi, OpPushAf, OpLdAA16, OpCpD8};

  // Shadow copy of the architectural state.
  logic [7:0]  cpu_regs [NumRegs];
  logic [15:0] pc_q, sp_q;
  logic [7:0]  tmp_lo, tmp_hi;
  logic        stop_q;

  coe_out_t cycle_results [$];
  int       n_errors, n_sent, n_checked;
  bit       quiet;

  // Clock: 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [15:0] pair_rd(logic [1:0] p, bit af);
    case (p)
      2'd0: return {cpu_regs[RegB], cpu_regs[RegC]};
      2'd1: return {cpu_regs[RegD], cpu_regs[RegE]};
      2'd2: return {cpu_regs[RegH], cpu_regs[RegL]};
      default: return af ? {cpu_regs[RegA], cpu_regs[RegF]} : sp_q;
    endcase
  endfunction

  function automatic void pair_wr(logic [1:0] p, bit af, logic [15:0] v);
    case (p)
      2'd0: {cpu_regs[RegB], cpu_regs[RegC]} = v;
      2'd1: {cpu_regs[RegD], cpu_regs[RegE]} = v;
      2'd2: {cpu_regs[RegH], cpu_regs[RegL]} = v;
      default: begin
        // Popping into AF clears the unused low nibble of the flags.
        if (af) {cpu_regs[RegA], cpu_regs[RegF]} = {v[15:4], 4'h0};
        else sp_q = v;
      end
    endcase
  endfunction

  function automatic void put_flags(bit z, bit n, bit h, bit c);
    cpu_regs[RegF] = {z, n, h, c, 4'h0};
  endfunction

  function automatic void compare_acc(logic [7:0] v);
    logic [7:0] a;
    a = cpu_regs[RegA];
    put_flags(a == v, 1'b1, v[3:0] > a[3:0], v > a);
  endfunction

  // Works out one machine cycle and advances the shadow state.
  function automatic coe_out_t exec_cycle(coe_in_t c);
    coe_out_t   r;
    logic [15:0] pc1, ret, pv;
    logic [1:0]  p;
    bit          bad, take;
    logic [2:0]  ri;
    logic [7:0]  v;
    r    = '0;
    bad  = 1'b0;
    p    = c.op[5:4];
    pc1  = pc_q + 16'd1;
    if (c.prefixed) bad = 1'b1;
    else begin
      case (c.op)
        OpNop, OpDi: if (c.phase == 3'd0) pc_q = pc1; else bad = 1'b1;
        OpStop: begin
          if (c.phase == 3'd0) begin pc_q = pc1; r.next_phase = 3'd1; end
          else if (c.phase == 3'd1) begin pc_q = pc1; stop_q = 1'b1; end
          else bad = 1'b1;
        end
        OpJr, OpJrNz, OpJrZ, OpJrNc: begin
          take = (c.op == OpJr) ? 1'b1 : (c.op == OpJrNz) ? !cpu_regs[RegF][FlagZ] :
                 (c.op == OpJrZ) ? cpu_regs[RegF][FlagZ] : !cpu_regs[RegF][FlagC];
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = pc1; r.address_valid = 1'b1;
            r.next_phase = take ? 3'd2 : 3'd1;
          end else if (c.phase == 3'd2) begin pc_q = pc1; r.next_phase = 3'd1; end
          else if (c.phase == 3'd1) pc_q = take ? pc_q + {{8{c.read_byte[7]}}, c.read_byte} : pc1;
          else bad = 1'b1;
        end
        OpLdBcD16, OpLdDeD16, OpLdHlD16, OpLdSpD16: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd2;
          end else if (c.phase == 3'd2) begin
            pc_q = pc1;
            pv = pair_rd(p, 1'b0);
            pair_wr(p, 1'b0, {pv[15:8], c.read_byte});
            r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd1;
          end else if (c.phase == 3'd1) begin
            pv = pair_rd(p, 1'b0);
            pair_wr(p, 1'b0, {c.read_byte, pv[7:0]});
            pc_q = pc1;
          end else bad = 1'b1;
        end
        OpLdBcA: begin
          if (c.phase == 3'd0) begin pc_q = pc1; r.next_phase = 3'd1; end
          else if (c.phase == 3'd1) begin
            r.bus_address = pair_rd(2'd0, 1'b0); r.address_valid = 1'b1;
            r.store_byte = cpu_regs[RegA]; r.store_valid = 1'b1;
          end else bad = 1'b1;
        end
        OpIncBc, OpIncDe, OpIncHl, OpIncSp, OpDecBc: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1;
            pair_wr(p, 1'b0, pair_rd(p, 1'b0) + ((c.op == OpDecBc) ? 16'hFFFF : 16'd1));
            r.next_phase = 3'd1;
          end else if (c.phase != 3'd1) bad = 1'b1;
        end
        OpIncC, OpIncE, OpIncL, OpIncA: begin
          if (c.phase == 3'd0) begin
            ri = (c.op == OpIncC) ? RegC : (c.op == OpIncE) ? RegE :
                 (c.op == OpIncL) ? RegL : RegA;
            v = cpu_regs[ri] + 8'd1;
            cpu_regs[ri] = v;
            pc_q = pc1;
            put_flags(v == 8'd0, 1'b0, v[3:0] == 4'd0, cpu_regs[RegF][FlagC]);
          end else bad = 1'b1;
        end
        OpLdBD8, OpLdCD8, OpLdAD8, OpCpD8: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd1;
          end else if (c.phase == 3'd1) begin
            pc_q = pc1;
            case (c.op)
              OpLdBD8: cpu_regs[RegB] = c.read_byte;
              OpLdCD8: cpu_regs[RegC] = c.read_byte;
              OpLdAD8: cpu_regs[RegA] = c.read_byte;
              default: compare_acc(c.read_byte);
            endcase
          end else bad = 1'b1;
        end
        OpLdBA, OpLdCA, OpLdAB, OpLdAC, OpLdAH, OpLdAL, OpXorA, OpOrC, OpCpB: begin
          if (c.phase != 3'd0) bad = 1'b1;
          else begin
            pc_q = pc1;
            case (c.op)
              OpLdBA: cpu_regs[RegB] = cpu_regs[RegA];
              OpLdCA: cpu_regs[RegC] = cpu_regs[RegA];
              OpLdAB: cpu_regs[RegA] = cpu_regs[RegB];
              OpLdAC: cpu_regs[RegA] = cpu_regs[RegC];
              OpLdAH: cpu_regs[RegA] = cpu_regs[RegH];
              OpLdAL: cpu_regs[RegA] = cpu_regs[RegL];
              OpXorA: begin cpu_regs[RegA] = '0; put_flags(1'b1, 1'b0, 1'b0, 1'b0); end
              OpOrC: begin
                cpu_regs[RegA] = cpu_regs[RegA] | cpu_regs[RegC];
                put_flags(cpu_regs[RegA] == 8'd0, 1'b0, 1'b0, 1'b0);
              end
              default: compare_acc(cpu_regs[RegB]);
            endcase
          end
        end
        OpPopBc, OpPopDe, OpPopHl, OpPopAf: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = sp_q; r.address_valid = 1'b1; r.next_phase = 3'd2;
          end else if (c.phase == 3'd2) begin
            pv = pair_rd(p, 1'b1);
            pair_wr(p, 1'b1, {pv[15:8], c.read_byte});
            sp_q = sp_q + 16'd1; r.bus_address = sp_q; r.address_valid = 1'b1;
            r.next_phase = 3'd1;
          end else if (c.phase == 3'd1) begin
            pv = pair_rd(p, 1'b1);
            pair_wr(p, 1'b1, {c.read_byte, pv[7:0]});
            sp_q = sp_q + 16'd1;
          end else bad = 1'b1;
        end
        OpPushBc, OpPushDe, OpPushHl, OpPushAf: begin
          if (c.phase == 3'd0) begin pc_q = pc1; r.next_phase = 3'd3; end
          else if (c.phase == 3'd3 || c.phase == 3'd2) begin
            sp_q = sp_q - 16'd1; r.bus_address = sp_q; r.address_valid = 1'b1;
            r.store_valid = 1'b1;
            pv = pair_rd(p, 1'b1);
            r.store_byte = (c.phase == 3'd3) ? pv[15:8] : pv[7:0];
            r.next_phase = c.phase - 3'd1;
          end else if (c.phase != 3'd1) bad = 1'b1;
        end
        OpJp, OpLdA16A, OpLdAA16: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd3;
          end else if (c.phase == 3'd3) begin
            pc_q = pc1; tmp_lo = c.read_byte;
            r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd2;
          end else if (c.phase == 3'd2) begin
            pc_q = pc1; r.next_phase = 3'd1;
            if (c.op != OpJp) begin
              r.bus_address = {c.read_byte, tmp_lo}; r.address_valid = 1'b1;
            end
            if (c.op == OpLdA16A) begin
              r.store_byte = cpu_regs[RegA]; r.store_valid = 1'b1;
            end
          end else if (c.phase == 3'd1) begin
            if (c.op == OpJp) pc_q = {c.read_byte, tmp_lo};
            else if (c.op == OpLdAA16) cpu_regs[RegA] = c.read_byte;
          end else bad = 1'b1;
        end
        OpRet: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = sp_q; r.address_valid = 1'b1;
            sp_q = sp_q + 16'd1; r.next_phase = 3'd3;
          end else if (c.phase == 3'd3) begin
            tmp_lo = c.read_byte; r.bus_address = sp_q; r.address_valid = 1'b1;
            sp_q = sp_q + 16'd1; r.next_phase = 3'd2;
          end else if (c.phase == 3'd2) begin
            pc_q = {c.read_byte, tmp_lo}; r.next_phase = 3'd1;
          end else if (c.phase != 3'd1) bad = 1'b1;
        end
        OpCall: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd5;
          end else if (c.phase == 3'd5) begin
            pc_q = pc1; tmp_lo = c.read_byte;
            r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd4;
          end else if (c.phase == 3'd4) begin
            ret = pc1;
            pc_q = {c.read_byte, tmp_lo};
            tmp_hi = ret[7:0];
            tmp_lo = ret[15:8];
            r.next_phase = 3'd3;
          end else if (c.phase == 3'd3 || c.phase == 3'd2) begin
            sp_q = sp_q - 16'd1; r.bus_address = sp_q; r.address_valid = 1'b1;
            r.store_valid = 1'b1;
            r.store_byte = (c.phase == 3'd3) ? tmp_lo : tmp_hi;
            r.next_phase = c.phase - 3'd1;
          end else if (c.phase != 3'd1) bad = 1'b1;
        end
        OpLdAHli: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = pair_rd(2'd2, 1'b0); r.address_valid = 1'b1;
            pair_wr(2'd2, 1'b0, pair_rd(2'd2, 1'b0) + 16'd1); r.next_phase = 3'd1;
          end else if (c.phase == 3'd1) cpu_regs[RegA] = c.read_byte;
          else bad = 1'b1;
        end
        OpLdhA8A, OpLdhAA8: begin
          if (c.phase == 3'd0) begin
            pc_q = pc1; r.bus_address = pc1; r.address_valid = 1'b1; r.next_phase = 3'd2;
          end else if (c.phase == 3'd2) begin
            pc_q = pc1; r.bus_address = HighPage | {8'h00, c.read_byte};
            r.address_valid = 1'b1;
            r.next_phase = 3'd1;
            if (c.op == OpLdhA8A) begin
              r.store_byte = cpu_regs[RegA]; r.store_valid = 1'b1;
            end
          end else if (c.phase == 3'd1) begin
            if (c.op == OpLdhAA8) cpu_regs[RegA] = c.read_byte;
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
    end
    // A failed cycle shows no bus activity; the state was left alone above.
    if (bad) r = '0;
    r.failed          = bad;
    r.stop_requested  = stop_q;
    r.program_counter = pc_q;
    return r;
  endfunction

  // Directed cycles. Rows with a typed result are checked against it; the
  // predictor still runs on them so that the shadow state keeps in step.
  typedef struct {
    coe_in_t  cyc;
    bit       typed;
    coe_out_t res;
  } dir_row_t;

  function automatic coe_out_t fixed_res(logic [2:0] np, bit f, logic [15:0] pc, bit st);
    coe_out_t r;
    r = '0;
    r.next_phase = np; r.failed = f; r.program_counter = pc; r.stop_requested = st;
    return r;
  endfunction

  function automatic dir_row_t row(logic [7:0] op, bit pre, logic [2:0] ph, logic [7:0] rb);
    dir_row_t d;
    d.cyc   = '{op: op, prefixed: pre, phase: ph, read_byte: rb};
    d.typed = 1'b0;
    d.res   = '0;
    return d;
  endfunction

  function automatic dir_row_t row_t(logic [7:0] op, bit pre, logic [2:0] ph,
                                     coe_out_t r);
    dir_row_t d;
    d       = row(op, pre, ph, 8'h00);
    d.typed = 1'b1;
    d.res   = r;
    return d;
  endfunction

  task automatic idle_burst();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 14)) @(negedge clk_i);
  endtask

  // Presents one cycle and waits for its transfer, then files the expectation.
  task automatic send_cycle(coe_in_t c, bit typed, coe_out_t typed_res);
    coe_out_t p;
    if (!quiet && $urandom_range(0, 9) == 0) idle_burst();
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    p = exec_cycle(c);
    cycle_results.push_back(typed ? typed_res : p);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Runs one instruction from its first cycle to completion with random bus data.
  task automatic run_instr(logic [7:0] op);
    coe_in_t    c;
    logic [2:0] ph;
    coe_out_t   dummy;
    ph    = '0;
    dummy = '0;
    do begin
      c = '{op: op, prefixed: 1'b0, phase: ph, read_byte: 8'($urandom)};
      send_cycle(c, 1'b0, dummy);
      ph = cycle_results[$].next_phase;
    end while (ph != 3'd0);
  endtask

  // Receiver side: stalls in bursts, then none at all near the end.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic cmp_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      n_errors++;
    end
  endtask

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    coe_out_t e, a;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (cycle_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        n_errors++;
      end else begin
        e = cycle_results.pop_front();
        n_checked++;
        cmp_field("next_phase", e.next_phase, a.next_phase);
        cmp_field("failed", e.failed, a.failed);
        cmp_field("bus_address", e.bus_address, a.bus_address);
        cmp_field("address_valid", e.address_valid, a.address_valid);
        cmp_field("store_byte", e.store_byte, a.store_byte);
        cmp_field("store_valid", e.store_valid, a.store_valid);
        cmp_field("stop_requested", e.stop_requested, a.stop_requested);
        cmp_field("program_counter", e.program_counter, a.program_counter);
      end
    end
  end

  // Main sequence.
  initial begin
    dir_row_t dir_rows [$];
    coe_in_t  c;
    coe_out_t dummy;
    int       wait_cnt;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    quiet       = 1'b0;
    n_errors = 0; n_sent = 0; n_checked = 0;
    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    pc_q = '0; sp_q = '0; tmp_lo = '0; tmp_hi = '0; stop_q = 1'b0;
    dummy = '0;

    // Reset values, the error cases and a bad phase are easy to type in.
    dir_rows.push_back(row_t(OpNop, 1'b0, 3'd0, fixed_res(3'd0, 1'b0, 16'd1, 1'b0)));
    dir_rows.push_back(row_t(OpNop, 1'b1, 3'd0, fixed_res(3'd0, 1'b1, 16'd1, 1'b0)));
    dir_rows.push_back(row_t(OpUnused, 1'b0, 3'd0, fixed_res(3'd0, 1'b1, 16'd1, 1'b0)));
    dir_rows.push_back(row_t(OpNop, 1'b0, 3'd7, fixed_res(3'd0, 1'b1, 16'd1, 1'b0)));
    dir_rows.push_back(row_t(OpStop, 1'b0, 3'd0, fixed_res(3'd1, 1'b0, 16'd2, 1'b0)));
    dir_rows.push_back(row_t(OpStop, 1'b0, 3'd1, fixed_res(3'd0, 1'b0, 16'd3, 1'b1)));
    dir_rows.push_back(row(OpLdAD8, 1'b0, 3'd0, 8'h00));
    dir_rows.push_back(row(OpLdAD8, 1'b0, 3'd1, 8'hFF));
    dir_rows.push_back(row(OpIncA, 1'b0, 3'd0, 8'h00));   // wraps to zero, half carry
    dir_rows.push_back(row(OpCpD8, 1'b0, 3'd0, 8'h00));
    dir_rows.push_back(row(OpCpD8, 1'b0, 3'd1, 8'hFF));
    dir_rows.push_back(row(OpXorA, 1'b0, 3'd0, 8'h00));
    dir_rows.push_back(row(OpJrZ, 1'b0, 3'd0, 8'h00));    // Z set, so taken
    dir_rows.push_back(row(OpJrZ, 1'b0, 3'd2, 8'h00));
    dir_rows.push_back(row(OpJrZ, 1'b0, 3'd1, 8'h80));    // most negative offset
    dir_rows.push_back(row(OpJrNz, 1'b0, 3'd0, 8'h00));   // not taken: offset skipped
    dir_rows.push_back(row(OpJrNz, 1'b0, 3'd1, 8'h7F));
    dir_rows.push_back(row(OpPopAf, 1'b0, 3'd0, 8'h00));
    dir_rows.push_back(row(OpPopAf, 1'b0, 3'd2, 8'hFF));  // low flag nibble forced clear
    dir_rows.push_back(row(OpPopAf, 1'b0, 3'd1, 8'hFF));
    dir_rows.push_back(row(OpPushAf, 1'b0, 3'd0, 8'h00));
    dir_rows.push_back(row(OpPushAf, 1'b0, 3'd3, 8'h00));
    dir_rows.push_back(row(OpPushAf, 1'b0, 3'd2, 8'h00));
    dir_rows.push_back(row(OpPushAf, 1'b0, 3'd1, 8'h00));
    dir_rows.push_back(row(OpDi, 1'b0, 3'd6, 8'hFF));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_cycle(dir_rows[i].cyc, dir_rows[i].typed, dir_rows[i].res);

    // Random part: mostly whole instructions with random bus data, with some
    // stray cycles (random opcodes, prefix, phases) mixed in.
    while (n_sent < 900) begin
      if (n_sent > 750) quiet = 1'b1;
      if (n_sent > 450 && n_sent < 460 && cycle_results.size() != 0) begin
        // Hold off until every outstanding result has drained.
        in_ch.valid <= 1'b0;
        while (cycle_results.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 99) < 85) run_instr(KnownOps[$urandom_range(0, 49)]);
      else begin
        c = '{op: 8'($urandom), prefixed: 1'($urandom), phase: 3'($urandom),
              read_byte: 8'($urandom)};
        send_cycle(c, 1'b0, dummy);
      end
    end
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (cycle_results.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (5) @(posedge clk_i);

    $display("Ran %0d machine cycles (directed and random) and checked %0d results.",
             n_sent, n_checked);
    if (n_errors == 0 && cycle_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (cycle_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, cycle_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
